FILE: hdl/rsc_pkg.sv
package rsc_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int DEPTH     = MAX_LEN + 1;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = 19;
    localparam int CHAR_W    = 8;
    localparam int ALPHABET  = 256;

    localparam logic [AW-1:0] MAX_LEN_A  = AW'(MAX_LEN);
    localparam logic [AW-1:0] ONE_A      = AW'(1);
    localparam logic [AW-1:0] BMAX_INIT  = AW'(ALPHABET - 1);
    localparam logic [CW-1:0] COUNT_MAX  = {CW{1'b1}};

    // one input word
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [CW-1:0] repeat_count;
        logic          too_long;
    } t_out_word;

    // text byte write from the loader
    typedef struct packed {
        logic              wr;
        logic [AW-1:0]     addr;
        logic [CHAR_W-1:0] chr;
    } t_load;

    // start of the suffix pass, n is the sentinel index
    typedef struct packed {
        logic          go;
        logic [AW-1:0] n;
    } t_start;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] count;
    } t_done;

endpackage

FILE: hdl/rsc_ram.sv
module rsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rsc_core.sv
module rsc_core
    import rsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_load  i_load,
    input  t_start i_start,
    input  logic   i_ack,
    output t_done  o_done
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SENT = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_CNT  = 4'd3;
    localparam logic [3:0] ST_PFX  = 4'd4;
    localparam logic [3:0] ST_PLC  = 4'd5;
    localparam logic [3:0] ST_ORD1 = 4'd6;
    localparam logic [3:0] ST_ORD2 = 4'd7;
    localparam logic [3:0] ST_RNK  = 4'd8;
    localparam logic [3:0] ST_KAS  = 4'd9;
    localparam logic [3:0] ST_SUM  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    localparam logic [2:0] SB0 = 3'd0;
    localparam logic [2:0] SB1 = 3'd1;
    localparam logic [2:0] SB2 = 3'd2;
    localparam logic [2:0] SB3 = 3'd3;
    localparam logic [2:0] SB4 = 3'd4;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_sub, n_sub;
    logic [AW-1:0] r_n, n_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_p, n_p;
    logic [AW:0]   r_k, n_k;
    logic [AW-1:0] r_bmax, n_bmax;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_key, n_key;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_r1, n_r1;
    logic [AW-1:0] r_pr1, n_pr1;
    logic [AW-1:0] r_pr2, n_pr2;
    logic          r_hv, n_hv;
    logic          r_phv, n_phv;
    logic [AW-1:0] r_h, n_h;
    logic [AW-1:0] r_last, n_last;
    logic [CW-1:0] r_sum, n_sum;
    logic          r_init, n_init;
    logic          r_sel, n_sel;

    // memory ports
    logic              tx_we;
    logic [AW-1:0]     tx_waddr, txa_raddr, txb_raddr;
    logic [CHAR_W-1:0] tx_wdata, d_txa, d_txb;
    logic              sa_we;
    logic [AW-1:0]     sa_waddr, sa_wdata, sa_raddr, d_sa;
    logic              rk0_we, rk1_we;
    logic [AW-1:0]     rk0_waddr, rk0_wdata, rk1_waddr, rk1_wdata;
    logic [AW-1:0]     rk_raddr, d_rk0, d_rk1, d_rko;
    logic              cnt_we;
    logic [AW-1:0]     cnt_waddr, cnt_wdata, cnt_raddr, d_cnt;
    logic              tmp_we;
    logic [AW-1:0]     tmp_waddr, tmp_wdata, tmp_raddr, d_tmp;

    // shared arithmetic
    logic [AW:0]   bk_sum, ih_sum, jh_sum, k_nx;
    logic [AW-1:0] p_nx, acc_nx, lcp_diff;
    logic [CW:0]   sum_nx;
    logic          same;

    rsc_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_txa (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(tx_wdata),
        .i_raddr(txa_raddr), .o_rdata(d_txa));
    rsc_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_txb (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(tx_wdata),
        .i_raddr(txb_raddr), .o_rdata(d_txb));
    rsc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_sa (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(sa_waddr), .i_wdata(sa_wdata),
        .i_raddr(sa_raddr), .o_rdata(d_sa));
    rsc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_rk0 (
        .i_clk(i_clk), .i_we(rk0_we), .i_waddr(rk0_waddr), .i_wdata(rk0_wdata),
        .i_raddr(rk_raddr), .o_rdata(d_rk0));
    rsc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_rk1 (
        .i_clk(i_clk), .i_we(rk1_we), .i_waddr(rk1_waddr), .i_wdata(rk1_wdata),
        .i_raddr(rk_raddr), .o_rdata(d_rk1));
    rsc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(d_cnt));
    rsc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_tmp (
        .i_clk(i_clk), .i_we(tmp_we), .i_waddr(tmp_waddr), .i_wdata(tmp_wdata),
        .i_raddr(tmp_raddr), .o_rdata(d_tmp));

    assign d_rko    = r_sel ? d_rk1 : d_rk0;
    assign bk_sum   = {1'b0, r_pos} + r_k;
    assign ih_sum   = {1'b0, r_i} + {1'b0, r_h};
    assign jh_sum   = {1'b0, r_pos} + {1'b0, r_h};
    assign k_nx     = {r_k[AW-1:0], 1'b0};
    assign acc_nx   = r_acc + d_cnt;
    assign lcp_diff = d_tmp - r_last;
    assign sum_nx   = {1'b0, r_sum} + {{(CW+1-AW){1'b0}}, lcp_diff};
    assign same     = (r_i != '0) && (r_r1 == r_pr1) && (r_hv == r_phv)
                      && (!r_hv || (d_rko == r_pr2));
    assign p_nx     = same ? r_p : r_p + ONE_A;

    assign o_done.done  = (r_state == ST_DONE);
    assign o_done.count = r_sum;

    always_comb begin
        n_state = r_state;  n_sub = r_sub;   n_n = r_n;       n_i = r_i;
        n_p = r_p;          n_k = r_k;       n_bmax = r_bmax; n_acc = r_acc;
        n_key = r_key;      n_pos = r_pos;   n_r1 = r_r1;     n_pr1 = r_pr1;
        n_pr2 = r_pr2;      n_hv = r_hv;     n_phv = r_phv;   n_h = r_h;
        n_last = r_last;    n_sum = r_sum;   n_init = r_init; n_sel = r_sel;
        tx_we = 1'b0;  tx_waddr = '0;  tx_wdata = '0;  txa_raddr = '0;  txb_raddr = '0;
        sa_we = 1'b0;  sa_waddr = '0;  sa_wdata = '0;  sa_raddr = '0;
        rk0_we = 1'b0; rk0_waddr = '0; rk0_wdata = '0;
        rk1_we = 1'b0; rk1_waddr = '0; rk1_wdata = '0; rk_raddr = '0;
        cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
        tmp_we = 1'b0; tmp_waddr = '0; tmp_wdata = '0; tmp_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                // text, initial ranks and identity order are filled as bytes arrive
                if (i_load.wr) begin
                    tx_we = 1'b1;  tx_waddr = i_load.addr;  tx_wdata = i_load.chr;
                    rk0_we = 1'b1; rk0_waddr = i_load.addr;
                    rk0_wdata = {{(AW-CHAR_W){1'b0}}, i_load.chr};
                    tmp_we = 1'b1; tmp_waddr = i_load.addr; tmp_wdata = i_load.addr;
                end
                if (i_start.go) begin
                    n_n = i_start.n;
                    n_state = ST_SENT;
                end
            end
            ST_SENT: begin
                tx_we = 1'b1;  tx_waddr = r_n;  tx_wdata = '0;
                rk0_we = 1'b1; rk0_waddr = r_n; rk0_wdata = '0;
                tmp_we = 1'b1; tmp_waddr = r_n; tmp_wdata = r_n;
                n_bmax = BMAX_INIT;
                n_init = 1'b1;
                n_sel = 1'b0;
                n_i = '0;
                n_state = ST_CLR;
            end
            ST_CLR: begin
                cnt_we = 1'b1; cnt_waddr = r_i; cnt_wdata = '0;
                if (r_i == r_bmax) begin
                    n_i = '0; n_sub = SB0; n_state = ST_CNT;
                end else begin
                    n_i = r_i + ONE_A;
                end
            end
            ST_CNT: begin
                unique case (r_sub)
                    SB0: begin tmp_raddr = r_i; n_sub = SB1; end
                    SB1: begin rk_raddr = d_tmp; n_sub = SB2; end
                    SB2: begin cnt_raddr = d_rko; n_key = d_rko; n_sub = SB3; end
                    default: begin
                        cnt_we = 1'b1; cnt_waddr = r_key; cnt_wdata = d_cnt + ONE_A;
                        n_sub = SB0;
                        if (r_i == r_n) begin
                            n_i = '0; n_acc = '0; n_state = ST_PFX;
                        end else begin
                            n_i = r_i + ONE_A;
                        end
                    end
                endcase
            end
            ST_PFX: begin
                if (r_sub == SB0) begin
                    cnt_raddr = r_i; n_sub = SB1;
                end else begin
                    cnt_we = 1'b1; cnt_waddr = r_i; cnt_wdata = acc_nx;
                    n_acc = acc_nx;
                    n_sub = SB0;
                    if (r_i == r_bmax) begin
                        n_i = r_n; n_state = ST_PLC;
                    end else begin
                        n_i = r_i + ONE_A;
                    end
                end
            end
            ST_PLC: begin
                unique case (r_sub)
                    SB0: begin tmp_raddr = r_i; n_sub = SB1; end
                    SB1: begin n_pos = d_tmp; rk_raddr = d_tmp; n_sub = SB2; end
                    SB2: begin cnt_raddr = d_rko; n_key = d_rko; n_sub = SB3; end
                    default: begin
                        cnt_we = 1'b1; cnt_waddr = r_key; cnt_wdata = d_cnt - ONE_A;
                        sa_we = 1'b1;  sa_waddr = d_cnt - ONE_A; sa_wdata = r_pos;
                        n_sub = SB0;
                        if (r_i != '0) begin
                            n_i = r_i - ONE_A;
                        end else if (r_init) begin
                            n_init = 1'b0;
                            n_k = (AW+1)'(1);
                            n_i = r_n;
                            n_p = '0;
                            n_state = ST_ORD1;
                        end else begin
                            n_i = '0; n_p = '0; n_state = ST_RNK;
                        end
                    end
                endcase
            end
            ST_ORD1: begin
                // suffixes with no second half lead the order
                tmp_we = 1'b1; tmp_waddr = r_p; tmp_wdata = r_i;
                n_p = r_p + ONE_A;
                if (r_i == r_n) begin
                    n_i = '0; n_sub = SB0; n_state = ST_ORD2;
                end else begin
                    n_i = r_i + ONE_A;
                end
            end
            ST_ORD2: begin
                if (r_sub == SB0) begin
                    sa_raddr = r_i; n_sub = SB1;
                end else begin
                    if ({1'b0, d_sa} >= r_k) begin
                        tmp_we = 1'b1; tmp_waddr = r_p;
                        tmp_wdata = AW'({1'b0, d_sa} - r_k);
                        n_p = r_p + ONE_A;
                    end
                    n_sub = SB0;
                    if (r_i == r_n) begin
                        n_i = '0; n_state = ST_CLR;
                    end else begin
                        n_i = r_i + ONE_A;
                    end
                end
            end
            ST_RNK: begin
                unique case (r_sub)
                    SB0: begin sa_raddr = r_i; n_sub = SB1; end
                    SB1: begin n_pos = d_sa; rk_raddr = d_sa; n_sub = SB2; end
                    SB2: begin
                        n_r1 = d_rko;
                        n_hv = (bk_sum <= {1'b0, r_n});
                        rk_raddr = (bk_sum <= {1'b0, r_n}) ? bk_sum[AW-1:0] : '0;
                        n_sub = SB3;
                    end
                    default: begin
                        if (r_sel) begin
                            rk0_we = 1'b1; rk0_waddr = r_pos;
                            rk0_wdata = same ? r_p - ONE_A : r_p;
                        end else begin
                            rk1_we = 1'b1; rk1_waddr = r_pos;
                            rk1_wdata = same ? r_p - ONE_A : r_p;
                        end
                        n_p = p_nx;
                        n_pr1 = r_r1; n_pr2 = d_rko; n_phv = r_hv;
                        n_sub = SB0;
                        if (r_i != r_n) begin
                            n_i = r_i + ONE_A;
                        end else begin
                            n_sel = ~r_sel;
                            if (p_nx > r_n || k_nx > {1'b0, r_n}) begin
                                n_i = '0; n_h = '0; n_state = ST_KAS;
                            end else begin
                                n_bmax = p_nx - ONE_A;
                                n_k = k_nx;
                                n_i = r_n + ONE_A - k_nx[AW-1:0];
                                n_p = '0;
                                n_state = ST_ORD1;
                            end
                        end
                    end
                endcase
            end
            ST_KAS: begin
                unique case (r_sub)
                    SB0: begin rk_raddr = r_i; n_sub = SB1; end
                    SB1: begin
                        n_h = (r_h != '0) ? r_h - ONE_A : r_h;
                        if (d_rko == '0) begin
                            n_sub = SB0;
                            if (r_i == r_n) begin
                                n_state = ST_SUM;
                                n_i = AW'(2); n_sum = '0; n_last = '0;
                                if (r_n < AW'(2)) n_state = ST_DONE;
                            end else begin
                                n_i = r_i + ONE_A;
                            end
                        end else begin
                            n_key = d_rko; sa_raddr = d_rko - ONE_A; n_sub = SB2;
                        end
                    end
                    SB2: begin n_pos = d_sa; n_sub = SB3; end
                    SB3: begin
                        if (ih_sum <= {1'b0, r_n} && jh_sum <= {1'b0, r_n}) begin
                            txa_raddr = ih_sum[AW-1:0];
                            txb_raddr = jh_sum[AW-1:0];
                            n_sub = SB4;
                        end else begin
                            tmp_we = 1'b1; tmp_waddr = r_key; tmp_wdata = r_h;
                            n_sub = SB0;
                            if (r_i == r_n) begin
                                n_state = ST_SUM;
                                n_i = AW'(2); n_sum = '0; n_last = '0;
                                if (r_n < AW'(2)) n_state = ST_DONE;
                            end else begin
                                n_i = r_i + ONE_A;
                            end
                        end
                    end
                    default: begin
                        if (d_txa == d_txb) begin
                            n_h = r_h + ONE_A; n_sub = SB3;
                        end else begin
                            tmp_we = 1'b1; tmp_waddr = r_key; tmp_wdata = r_h;
                            n_sub = SB0;
                            if (r_i == r_n) begin
                                n_state = ST_SUM;
                                n_i = AW'(2); n_sum = '0; n_last = '0;
                                if (r_n < AW'(2)) n_state = ST_DONE;
                            end else begin
                                n_i = r_i + ONE_A;
                            end
                        end
                    end
                endcase
            end
            ST_SUM: begin
                if (r_sub == SB0) begin
                    tmp_raddr = r_i; n_sub = SB1;
                end else begin
                    if (d_tmp > r_last) begin
                        n_sum = (sum_nx > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_nx[CW-1:0];
                    end
                    n_last = d_tmp;
                    n_sub = SB0;
                    if (r_i == r_n) begin
                        n_state = ST_DONE;
                    end else begin
                        n_i = r_i + ONE_A;
                    end
                end
            end
            ST_DONE: begin
                if (i_ack) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sub   <= SB0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;       r_i <= n_i;       r_p <= n_p;       r_k <= n_k;
        r_bmax <= n_bmax; r_acc <= n_acc;   r_key <= n_key;   r_pos <= n_pos;
        r_r1 <= n_r1;     r_pr1 <= n_pr1;   r_pr2 <= n_pr2;   r_hv <= n_hv;
        r_phv <= n_phv;   r_h <= n_h;       r_last <= n_last; r_sum <= n_sum;
        r_init <= n_init; r_sel <= n_sel;
    end

endmodule

FILE: hdl/repeated_substring_counter.sv
// Repeated-substring counter. A string streams in one byte word per cycle, the final byte
// flagged by last_char; bytes past 1024 are dropped and flagged as too_long in the result.
// On the final byte the block appends a zero sentinel, builds the suffix array by
// prefix doubling with counting sorts, derives adjacent LCPs Kasai-style and returns the
// number of distinct substrings that occur at least twice (saturating at 2^19-1). One
// result word is produced per string. All work runs through one small sequencer over
// simple dual-port RAMs with registered reads, one memory access step at a time. For a
// string of L bytes there is one initial character sort and at most floor(log2(L))+1
// doubling rounds, followed by the LCP and summing passes. Input is not accepted while a
// string is being processed; byte words of the next string are taken as soon as the
// result has moved into the output register, even if it has not yet been read.
module repeated_substring_counter
    import rsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [AW-1:0] r_len;       // bytes stored so far
    logic          r_ovf;       // a byte was dropped
    logic          r_busy;      // string handed to the core, result not yet moved
    logic          r_tl;        // too_long of the string being processed
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic   in_acc;
    logic   stored;
    logic   move;
    t_load  load;
    t_start start;
    t_done  done;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign stored     = (r_len < MAX_LEN_A);

    // byte lands at the current length, sentinel goes right after the last stored byte
    assign load.wr    = in_acc && stored;
    assign load.addr  = r_len;
    assign load.chr   = i_in_word.char_code;
    assign start.go   = in_acc && i_in_word.last_char;
    assign start.n    = stored ? r_len + ONE_A : r_len;

    // result moves when the output register is empty or being emptied
    assign move = done.done && (!r_out_valid || i_out_ready);

    rsc_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (load),
        .i_start(start),
        .i_ack  (move),
        .o_done (done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in_word.last_char) begin
                    r_len  <= '0;
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end else if (stored) begin
                    r_len <= r_len + ONE_A;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (move) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start.go) begin
            r_tl <= r_ovf || !stored;
        end
        if (move) begin
            r_out_word.repeat_count <= done.count;
            r_out_word.too_long     <= r_tl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
